### hw/rtl/atce_pkg.sv
// ----------------------------------------------------------------------------
// atce_pkg: shared constants and helpers of the text console engine
// Screen geometry, cell constants and the colour table.
// ----------------------------------------------------------------------------
package atce_pkg;

	localparam int unsigned ScreenCols = 80;
	localparam int unsigned ScreenRows = 25;
	localparam int unsigned TabWidth   = 8;
	localparam int unsigned CellTotal  = ScreenCols * ScreenRows;
	localparam int unsigned AddrW      = 11;

	localparam logic [7:0]  StyleReset = 8'h0F;
	localparam logic [7:0]  ChSpace    = 8'h20;
	localparam logic [15:0] CellReset  = 16'h0F20;

	localparam logic [7:0] ChEsc = 8'h1B;
	localparam logic [7:0] ChCr  = 8'h0D;
	localparam logic [7:0] ChLf  = 8'h0A;
	localparam logic [7:0] ChBs  = 8'h08;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChBel = 8'h07;
	localparam logic [7:0] ChLbr = 8'h5B;
	localparam logic [7:0] ChSemi = 8'h3B;
	localparam logic [7:0] ChZero = 8'h30;
	localparam logic [7:0] ChNine = 8'h39;

	// escape finals
	localparam logic [7:0] FinHome  = 8'h48; // H
	localparam logic [7:0] FinHomeF = 8'h66; // f
	localparam logic [7:0] FinSgr   = 8'h6D; // m
	localparam logic [7:0] FinErase = 8'h4A; // J
	localparam logic [7:0] FinLine  = 8'h4B; // K
	localparam logic [7:0] FinUp    = 8'h41; // A
	localparam logic [7:0] FinDown  = 8'h42; // B
	localparam logic [7:0] FinRight = 8'h43; // C
	localparam logic [7:0] FinLeft  = 8'h44; // D

	localparam logic KindWrite = 1'b0;
	localparam logic KindRead  = 1'b1;

	function automatic logic [7:0] ansi_colour(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h00;
			3'd1: c = 8'h0C;
			3'd2: c = 8'h0A;
			3'd3: c = 8'h0E;
			3'd4: c = 8'h0B;
			3'd5: c = 8'h05;
			3'd6: c = 8'h03;
			default: c = 8'h0F;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/atce_in_if.sv
// ----------------------------------------------------------------------------
// atce_in_if: request channel of the text console engine
// Valid/ready handshake carrying one byte write or one cell read.
// ----------------------------------------------------------------------------
interface atce_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  char_byte;
	logic [10:0] read_address;
	modport source (output valid, kind, char_byte, read_address, input ready);
	modport sink   (input valid, kind, char_byte, read_address, output ready);
endinterface

### hw/rtl/atce_out_if.sv
// ----------------------------------------------------------------------------
// atce_out_if: result channel of the text console engine
// Valid/ready handshake carrying cursor, style and a read cell.
// ----------------------------------------------------------------------------
interface atce_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] cursor_position;
	logic [7:0]  text_style;
	logic [15:0] cell_data;
	modport source (output valid, cursor_position, text_style, cell_data, input ready);
	modport sink   (input valid, cursor_position, text_style, cell_data, output ready);
endinterface

### hw/rtl/ansi_text_console_engine_core.sv
// ----------------------------------------------------------------------------
// ansi_text_console_engine_core: ANSI text console engine
// Cell store, cursor, style and ESC [ parser behind valid/ready channels.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 2000-entry cell store to blank before the
// first request is accepted. One request is handled at a time through the
// cell memory (one access per cycle). A plain byte, a control byte or a
// cursor move passes through the decode and result states; a read or a digit
// adds a read or digit state between them. A tab fills one cell at a time (up
// to 8); an erase blanks one cell at a time (up to 2000). A scroll moves each
// cell of the lower rows up one row, with a read and a write state per moved
// cell, then blanks the last row. The result is held in an output register,
// so the next request may be accepted and worked on while the previous result
// waits; it then holds in its last cycle until the register is free.
module ansi_text_console_engine_core (
	input  logic clk,
	input  logic arst_n,
	atce_in_if.sink   req,
	atce_out_if.source rsp
);
	import atce_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DECODE, ST_READ, ST_FILL, ST_SCR_RD, ST_SCR_WR,
		ST_SCR_BLANK, ST_DIGIT, ST_RESULT
	} state_t;

	typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_BRACKET} pmode_t;

	localparam logic [AddrW-1:0] LastCell = AddrW'(CellTotal - 1);
	localparam logic [AddrW-1:0] LastRowStart = AddrW'(CellTotal - ScreenCols);
	localparam logic [AddrW:0]   TotalW = (AddrW+1)'(CellTotal);
	// reciprocal of the row length, exact for every 12-bit cursor value
	localparam int unsigned      RowShift = 18;
	localparam logic [11:0]      RowRecip = 12'((1 << RowShift) / ScreenCols + 1);

	logic [15:0] mem [CellTotal];
	logic [15:0] rdata_q;

	state_t      state_q;
	pmode_t      pmode_q;
	logic [AddrW:0] cursor_q;   // one extra bit: may reach CellTotal or beyond before scroll
	logic [7:0]  style_q;
	logic [15:0] acc_q, p0_q, p1_q;
	logic        slot_q;
	logic [7:0]  ch_q;
	logic        kind_q;
	logic [AddrW-1:0] addr_q;
	logic [AddrW:0]   ptr_q, end_q;
	logic [15:0] prod_q;

	logic        out_valid_q;
	logic [10:0] out_cur_q;
	logic [7:0]  out_style_q;
	logic [15:0] out_cell_q;

	// memory port
	logic            mem_we;
	logic [AddrW-1:0] mem_waddr, mem_raddr;
	logic [15:0]     mem_wdata;
	logic            mem_re;

	// row/col of cursor by reciprocal multiplication (cursor < 2^12)
	logic [23:0]    row_prod;
	logic [AddrW:0] cur_row, cur_col, row_start;
	always_comb begin
		row_prod = 24'(cursor_q) * 24'(RowRecip);
		cur_row = (AddrW+1)'(row_prod >> RowShift);
		row_start = (AddrW+1)'(cur_row * ScreenCols);
		cur_col = cursor_q - row_start;
	end

	logic [15:0] blank;
	assign blank = {style_q, ChSpace};

	logic res_load;
	assign res_load = (state_q == ST_RESULT) && (cursor_q < TotalW)
		&& (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// combinational memory control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = blank;
		mem_re = 1'b0;
		mem_raddr = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q[AddrW-1:0];
				mem_wdata = CellReset;
			end
			ST_READ: mem_re = 1'b1;
			ST_DECODE: begin
				if (kind_q == KindRead) mem_re = 1'b1;
			end
			ST_FILL: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q[AddrW-1:0];
			end
			ST_SCR_RD: begin
				mem_re = 1'b1;
				mem_raddr = AddrW'(ptr_q + (AddrW+1)'(ScreenCols));
			end
			ST_SCR_WR: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q[AddrW-1:0];
				mem_wdata = rdata_q;
			end
			ST_SCR_BLANK: begin
				mem_we = 1'b1;
				mem_waddr = ptr_q[AddrW-1:0];
			end
			default: ;
		endcase
		if (state_q == ST_DECODE && kind_q == KindWrite && pmode_q == PM_NORMAL
				&& ch_q != ChEsc && ch_q != ChCr && ch_q != ChLf && ch_q != ChBs
				&& ch_q != ChTab && ch_q != ChBel && cursor_q < TotalW) begin
			mem_we = 1'b1;
			mem_waddr = cursor_q[AddrW-1:0];
			mem_wdata = {style_q, ch_q};
		end
	end

	// final-byte helpers
	logic [15:0] cnt;
	logic [AddrW:0] hr, hk, lim, mv;
	logic [7:0] sgr0, sgr1;

	function automatic logic [7:0] sgr(input logic [7:0] st, input logic [15:0] code);
		logic [7:0] r;
		logic [7:0] bg;
		r = st;
		bg = ansi_colour(3'(code - 16'd40));
		if (code == 16'd0) r = StyleReset;
		else if (code >= 16'd30 && code <= 16'd37) r = ansi_colour(3'(code - 16'd30));
		else if (code >= 16'd40 && code <= 16'd47)
			r = {1'b0, bg[2:0], st[3:0]};
		return r;
	endfunction

	logic [15:0] fin_p0, fin_p1;
	always_comb begin
		fin_p0 = slot_q ? p0_q : acc_q;
		fin_p1 = slot_q ? acc_q : p1_q;
		cnt = (fin_p0 == 16'd0) ? 16'd1 : fin_p0;
		hr = (fin_p0 == 16'd0) ? '0 :
			((fin_p0 - 16'd1) >= 16'(ScreenRows) ? (AddrW+1)'(ScreenRows-1)
				: (AddrW+1)'(fin_p0 - 16'd1));
		hk = (fin_p1 == 16'd0) ? '0 :
			((fin_p1 - 16'd1) >= 16'(ScreenCols) ? (AddrW+1)'(ScreenCols-1)
				: (AddrW+1)'(fin_p1 - 16'd1));
		lim = '0;
		mv = '0;
		sgr0 = sgr(style_q, fin_p0);
		sgr1 = slot_q ? sgr(sgr0, fin_p1) : sgr0;
		case (ch_q)
			FinUp: lim = cur_row;
			FinDown: lim = (AddrW+1)'(ScreenRows-1) - cur_row;
			FinRight: lim = (AddrW+1)'(LastCell) - cursor_q;
			FinLeft: lim = cur_col;
			default: ;
		endcase
		mv = (cnt < 16'(lim)) ? (AddrW+1)'(cnt) : lim;
	end

	logic [AddrW:0] tab_stop;
	assign tab_stop = (AddrW+1)'(((cursor_q / TabWidth) + 1) * TabWidth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			pmode_q <= PM_NORMAL;
			cursor_q <= '0;
			style_q <= StyleReset;
			acc_q <= '0;
			p0_q <= '0;
			p1_q <= '0;
			slot_q <= 1'b0;
			ptr_q <= '0;
			end_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == (AddrW+1)'(LastCell)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						kind_q <= req.kind;
						ch_q <= req.char_byte;
						addr_q <= req.read_address;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_RESULT;
					if (kind_q == KindRead) begin
						state_q <= ST_READ;
					end else begin
						unique case (pmode_q)
							PM_ESC: pmode_q <= (ch_q == ChLbr) ? PM_BRACKET : PM_NORMAL;
							PM_BRACKET: begin
								if (ch_q >= ChZero && ch_q <= ChNine) begin
									prod_q <= 16'(acc_q * 16'd10);
									state_q <= ST_DIGIT;
								end else if (ch_q == ChSemi) begin
									if (!slot_q) begin
										p0_q <= acc_q;
										slot_q <= 1'b1;
										acc_q <= '0;
									end
								end else begin
									pmode_q <= PM_NORMAL;
									acc_q <= '0;
									p0_q <= '0;
									p1_q <= '0;
									slot_q <= 1'b0;
									case (ch_q)
										FinHome, FinHomeF:
											cursor_q <= (AddrW+1)'(hr * ScreenCols) + hk;
										FinSgr: style_q <= sgr1;
										FinErase: begin
											state_q <= ST_FILL;
											if (fin_p0 == 16'd2) begin
												ptr_q <= '0;
												cursor_q <= '0;
											end else begin
												ptr_q <= cursor_q;
											end
											end_q <= TotalW;
										end
										FinLine: begin
											state_q <= ST_FILL;
											ptr_q <= cursor_q;
											end_q <= row_start + (AddrW+1)'(ScreenCols);
										end
										FinUp: cursor_q <= cursor_q - (AddrW+1)'(mv * ScreenCols);
										FinDown: cursor_q <= cursor_q + (AddrW+1)'(mv * ScreenCols);
										FinRight: cursor_q <= cursor_q + mv;
										FinLeft: cursor_q <= cursor_q - mv;
										default: ;
									endcase
								end
							end
							default: begin
								case (ch_q)
									ChEsc: begin
										pmode_q <= PM_ESC;
										acc_q <= '0;
										p0_q <= '0;
										p1_q <= '0;
										slot_q <= 1'b0;
									end
									ChCr: cursor_q <= row_start;
									ChLf: cursor_q <= cursor_q + (AddrW+1)'(ScreenCols);
									ChBs: if (cursor_q != '0) cursor_q <= cursor_q - 1'b1;
									ChTab: begin
										ptr_q <= cursor_q;
										end_q <= (tab_stop > TotalW) ? TotalW : tab_stop;
										state_q <= ST_FILL;
									end
									ChBel: ;
									default: cursor_q <= cursor_q + 1'b1;
								endcase
							end
						endcase
					end
				end
				ST_DIGIT: begin
					acc_q <= prod_q + {12'd0, ch_q[3:0]};
					state_q <= ST_RESULT;
				end
				ST_FILL: begin
					// tab moves the cursor along with the fill
					if (pmode_q == PM_NORMAL && ch_q == ChTab) cursor_q <= ptr_q + 1'b1;
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q + 1'b1 >= end_q) state_q <= ST_RESULT;
				end
				ST_SCR_RD: state_q <= ST_SCR_WR;
				ST_SCR_WR: begin
					ptr_q <= ptr_q + 1'b1;
					state_q <= (ptr_q + 1'b1 == (AddrW+1)'(LastRowStart)) ? ST_SCR_BLANK
						: ST_SCR_RD;
				end
				ST_SCR_BLANK: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == (AddrW+1)'(LastCell)) begin
						cursor_q <= (AddrW+1)'(LastRowStart);
						state_q <= ST_RESULT;
					end
				end
				ST_READ: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (cursor_q >= TotalW) begin
						ptr_q <= '0;
						state_q <= ST_SCR_RD;
					end else if (res_load) begin
						out_cur_q <= cursor_q[AddrW-1:0];
						out_style_q <= style_q;
						out_cell_q <= (kind_q == KindRead && 12'(addr_q) < TotalW)
							? rdata_q : 16'd0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.cursor_position = out_cur_q;
	assign rsp.text_style = out_style_q;
	assign rsp.cell_data = out_cell_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> state_q == ST_IDLE)
		else $error("request accepted while busy");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cursor_q < TotalW)
		else $error("cursor out of range when idle");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q)
		else $error("result dropped");
	a_slot_mode: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q |-> pmode_q == PM_BRACKET)
		else $error("parameter slot set outside bracket mode");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: text console engine check
// Drives byte writes and cell reads through the request channel with random
// gaps, back-pressures the result channel, and compares every result against
// a local model of the screen, cursor, style and escape parser.
// ----------------------------------------------------------------------------
module testbench;
	import atce_pkg::*;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [7:0]  text_style;
		logic [15:0] cell_data;
	} console_result_t;

	typedef enum logic [1:0] {PARSE_TEXT, PARSE_ESC, PARSE_CSI} parse_state_e;

	localparam logic [7:0] FinOther = 8'h7A; // z, not a known final

	class console_scoreboard;
		logic [15:0]     cells [CellTotal];
		int unsigned     cur;
		logic [7:0]      sty;
		parse_state_e    mode;
		logic [15:0]     acc;
		logic [15:0]     prm [2];
		bit              slot;
		console_result_t pending [$];
		logic [7:0]      palette [8];
		int              errors, writes, reads, scrolls;

		function new();
			palette = '{8'h00, 8'h0C, 8'h0A, 8'h0E, 8'h0B, 8'h05, 8'h03, 8'h0F};
			foreach (cells[i]) cells[i] = CellReset;
			cur = 0;
			sty = StyleReset;
			mode = PARSE_TEXT;
			clear_params();
		endfunction

		function void clear_params();
			acc = 0;
			prm[0] = 0;
			prm[1] = 0;
			slot = 0;
		endfunction

		function void blank_span(int unsigned from, int unsigned upto);
			for (int unsigned i = from; i < upto && i < CellTotal; i++)
				cells[i] = {sty, ChSpace};
		endfunction

		function void apply_colour(logic [15:0] code);
			if (code == 0)
				sty = StyleReset;
			else if (code >= 30 && code <= 37)
				sty = palette[code - 30];
			else if (code >= 40 && code <= 47)
				sty = {1'b0, palette[code - 40][2:0], sty[3:0]};
		endfunction

		function void run_final(logic [7:0] c);
			int unsigned p0, n, row, col, lim, r, k;
			p0 = prm[0];
			n = (p0 == 0) ? 1 : p0;
			row = cur / ScreenCols;
			col = cur % ScreenCols;
			case (c)
				FinHome, FinHomeF: begin
					r = (p0 == 0) ? 0 : p0 - 1;
					k = (prm[1] == 0) ? 0 : prm[1] - 1;
					if (r >= ScreenRows) r = ScreenRows - 1;
					if (k >= ScreenCols) k = ScreenCols - 1;
					cur = r * ScreenCols + k;
				end
				FinSgr: begin
					apply_colour(prm[0]);
					if (slot) apply_colour(prm[1]);
				end
				FinErase: begin
					if (p0 == 2) begin
						blank_span(0, CellTotal);
						cur = 0;
					end else begin
						blank_span(cur, CellTotal);
					end
				end
				FinLine: blank_span(cur, (row + 1) * ScreenCols);
				FinUp: begin
					lim = row;
					cur -= ((n < lim) ? n : lim) * ScreenCols;
				end
				FinDown: begin
					lim = ScreenRows - 1 - row;
					cur += ((n < lim) ? n : lim) * ScreenCols;
				end
				FinRight: begin
					lim = CellTotal - 1 - cur;
					cur += (n < lim) ? n : lim;
				end
				FinLeft: cur -= (n < col) ? n : col;
				default: ;
			endcase
		endfunction

		function void put_byte(logic [7:0] c);
			int unsigned stop;
			if (mode == PARSE_ESC) begin
				mode = (c == ChLbr) ? PARSE_CSI : PARSE_TEXT;
			end else if (mode == PARSE_CSI) begin
				if (c >= ChZero && c <= ChNine) begin
					acc = acc * 16'd10 + 16'(c - ChZero);
				end else if (c == ChSemi) begin
					if (!slot) begin
						prm[0] = acc;
						slot = 1;
						acc = 0;
					end
				end else begin
					prm[slot] = acc;
					run_final(c);
					mode = PARSE_TEXT;
					clear_params();
				end
			end else begin
				case (c)
					ChEsc: begin
						mode = PARSE_ESC;
						clear_params();
					end
					ChCr:  cur -= cur % ScreenCols;
					ChLf:  cur += ScreenCols;
					ChBs:  if (cur > 0) cur--;
					ChTab: begin
						stop = (cur / TabWidth + 1) * TabWidth;
						while (cur < stop && cur < CellTotal) begin
							cells[cur] = {sty, ChSpace};
							cur++;
						end
					end
					ChBel: ;
					default: begin
						if (cur < CellTotal) cells[cur] = {sty, c};
						cur++;
					end
				endcase
			end
			// scroll up one row once the cursor runs off the end
			if (cur >= CellTotal) begin
				for (int unsigned i = 0; i < CellTotal - ScreenCols; i++)
					cells[i] = cells[i + ScreenCols];
				blank_span(CellTotal - ScreenCols, CellTotal);
				cur = CellTotal - ScreenCols;
				scrolls++;
			end
		endfunction

		function void note_request(logic k, logic [7:0] c, logic [10:0] a);
			console_result_t res;
			res.cell_data = '0;
			if (k == KindWrite) begin
				put_byte(c);
				writes++;
			end else begin
				if (a < CellTotal) res.cell_data = cells[a];
				reads++;
			end
			res.cursor_position = cur[10:0];
			res.text_style = sty;
			pending.push_back(res);
		endfunction

		function void check_response(console_result_t got);
			console_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.cursor_position !== want.cursor_position) begin
				$display("%0t: cursor_position expected %0d actual %0d", $time,
					want.cursor_position, got.cursor_position);
				errors++;
			end
			if (got.text_style !== want.text_style) begin
				$display("%0t: text_style expected %h actual %h", $time,
					want.text_style, got.text_style);
				errors++;
			end
			if (got.cell_data !== want.cell_data) begin
				$display("%0t: cell_data expected %h actual %h", $time,
					want.cell_data, got.cell_data);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	atce_in_if  req ();
	atce_out_if rsp ();

	console_scoreboard sb;
	bit quiet;
	int hold_cycles;
	int sent;
	int sequences;

	ansi_text_console_engine_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("%0t: timeout", $time);
		$display("testbench: FAIL");
		$finish;
	end

	task automatic send_request(logic k, logic [7:0] c, logic [10:0] a);
		if (!quiet && $urandom_range(99) < 26) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.kind         <= k;
		req.char_byte    <= c;
		req.read_address <= a;
		do @(posedge clk); while (!req.ready);
		sb.note_request(k, c, a);
		sent++;
	endtask

	task automatic send_byte(logic [7:0] c);
		send_request(KindWrite, c, 11'($urandom_range(2047)));
	endtask

	task automatic send_read(logic [10:0] a);
		send_request(KindRead, 8'($urandom_range(255)), a);
	endtask

	task automatic send_number(int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// ESC [ p0 ; p1 final, with either parameter left out when negative
	task automatic send_csi(int p0, int p1, logic [7:0] fin);
		send_byte(ChEsc);
		send_byte(ChLbr);
		if (p0 >= 0) send_number(p0);
		if (p1 >= 0) begin
			send_byte(ChSemi);
			send_number(p1);
		end
		send_byte(fin);
		sequences++;
	endtask

	task automatic random_sequence();
		logic [7:0] finals [10];
		logic [7:0] fin;
		int p0, p1;
		finals = '{FinHome, FinHomeF, FinSgr, FinErase, FinLine,
			FinUp, FinDown, FinRight, FinLeft, FinOther};
		fin = finals[$urandom_range(9)];
		p0 = ($urandom_range(3) == 0) ? -1 : $urandom_range(30);
		p1 = ($urandom_range(1) == 0) ? -1 : $urandom_range(90);
		if (fin == FinSgr) begin
			p0 = ($urandom_range(3) == 0) ? 0 : 30 + $urandom_range(19);
			p1 = ($urandom_range(1) == 0) ? -1 : 30 + $urandom_range(19);
		end
		// keep screen erases rare, they can cost up to a whole sweep
		if (fin == FinErase && $urandom_range(3) != 0) fin = FinLine;
		send_csi(p0, p1, fin);
	endtask

	task automatic random_item();
		logic [7:0] ctl [5];
		int pick;
		ctl = '{ChCr, ChLf, ChBs, ChTab, ChBel};
		pick = $urandom_range(99);
		if (pick < 35) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
		end else if (pick < 50) begin
			send_byte(ctl[$urandom_range(4)]);
		end else if (pick < 75) begin
			random_sequence();
		end else if (pick < 80) begin
			// broken sequences: stray escape, or odd separators inside
			send_byte(ChEsc);
			send_byte(8'($urandom_range(255)));
			if ($urandom_range(1)) begin
				send_byte(ChLbr);
				send_byte(ChSemi);
				send_byte(ChSemi);
				send_number($urandom_range(99));
				send_byte(8'($urandom_range(255)));
			end
		end else begin
			send_read(11'($urandom_range(2047)));
		end
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				sb.check_response('{rsp.cursor_position, rsp.text_style, rsp.cell_data});
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_cycles--;
			end else if (quiet) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(99) >= 26);
			end
		end
	end

	initial begin
		int waited;
		sb = new();
		quiet = 0;
		hold_cycles = 0;
		sent = 0;
		sequences = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KindWrite;
		req.char_byte = '0;
		req.read_address = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners of the fields, controls and every final
		send_read(11'd0);
		send_read(11'(CellTotal - 1));
		send_read(11'd2047);
		send_byte(ChBs);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ChTab);
		send_byte(ChBel);
		send_byte(ChCr);
		send_byte(ChLf);
		send_byte(ChEsc);
		send_byte(8'h41);
		send_csi(31, 44, FinSgr);
		send_byte(8'h58);
		send_csi(0, -1, FinSgr);
		send_csi(99, 999, FinHome);
		send_csi(-1, 3, FinHomeF);
		send_csi(65535, -1, FinLeft);
		send_csi(3, -1, FinUp);
		send_csi(99999, -1, FinDown);
		send_csi(0, -1, FinRight);
		send_csi(-1, -1, FinLine);
		send_csi(7, 7, FinOther);
		send_csi(-1, -1, FinErase);
		send_csi(2, -1, FinErase);
		send_read(11'(CellTotal - 1));

		while (sent < 300) begin
			quiet = (sent >= 140 && sent < 200);
			if (sent >= 220 && sent < 224 && hold_cycles == 0) hold_cycles = 400;
			random_item();
		end
		// run off the bottom a few times to force scrolls
		repeat (30) send_byte(ChLf);
		send_csi(25, 80, FinHome);
		send_byte(8'h5A);
		send_read(11'(CellTotal - ScreenCols));
		@(posedge clk);
		req.valid <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 1_000_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending.size());
			sb.errors++;
		end
		$display("Covered %0d byte writes, %0d cell reads, %0d escape sequences, %0d scrolls.",
			sb.writes, sb.reads, sequences, sb.scrolls);
		$display("Mismatches seen: %0d", sb.errors);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
